// File: rtl/temp_scan_min_max_alarm_macros.svh
// assertion macros for the temperature scan supervisor
// no dependencies; included by the top level only
`ifndef TEMP_SCAN_MIN_MAX_ALARM_MACROS_SVH
`define TEMP_SCAN_MIN_MAX_ALARM_MACROS_SVH
`ifndef SYNTHESIS
`define TSMMA_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsmma: same-cycle check failed");
`define TSMMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsmma: next-cycle check failed");
`else
`define TSMMA_ASSERT(label, clk, rst_n, ante, cons)
`define TSMMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/tsmma_pkg.sv
// shared types, codes and constants of the temperature scan supervisor
// no dependencies
`default_nettype none

package tsmma_pkg;

  localparam int unsigned SensorCountDef = 16;

  localparam int unsigned TempW = 16;
  localparam int unsigned ClsW  = 3;
  localparam int unsigned IdxOW = 4;
  localparam int unsigned MaskW = 9;
  localparam int unsigned ScW   = 2;

  // threshold reset values
  localparam logic [15:0] LowSevereRst      = 16'hFFFB;
  localparam logic [15:0] LowModerateRst    = 16'hFFFE;
  localparam logic [15:0] LowWarnRst        = 16'h0000;
  localparam logic [15:0] HighSevereRst     = 16'd40;
  localparam logic [15:0] HighModerateRst   = 16'd38;
  localparam logic [15:0] HighWarnRst       = 16'd37;
  localparam logic [15:0] SpreadSevereRst   = 16'd80;
  localparam logic [15:0] SpreadModerateRst = 16'd30;

  // register map, one word each
  typedef enum logic [2:0] {
    REG_LOW_SEVERE,
    REG_LOW_MODERATE,
    REG_LOW_WARN,
    REG_HIGH_SEVERE,
    REG_HIGH_MODERATE,
    REG_HIGH_WARN,
    REG_SPREAD_SEVERE,
    REG_SPREAD_MODERATE
  } reg_idx_e;

  typedef enum logic [2:0] {
    CLS_NORMAL,
    CLS_LOW,
    CLS_LOW_MOD,
    CLS_LOW_SEV,
    CLS_HIGH,
    CLS_HIGH_MOD,
    CLS_HIGH_SEV
  } sensor_class_e;

  localparam logic [ScW-1:0] SPREAD_NORMAL   = 2'd0;
  localparam logic [ScW-1:0] SPREAD_SEVERE   = 2'd1;
  localparam logic [ScW-1:0] SPREAD_MODERATE = 2'd2;
  localparam logic [ScW-1:0] SPREAD_UNUSED   = 2'd3;

  localparam int unsigned MaskNormalBit   = 0;
  localparam int unsigned MaskSevereBit   = 7;
  localparam int unsigned MaskModerateBit = 8;

  typedef struct packed {
    logic signed [TempW-1:0] low_severe;
    logic signed [TempW-1:0] low_moderate;
    logic signed [TempW-1:0] low_warn;
    logic signed [TempW-1:0] high_severe;
    logic signed [TempW-1:0] high_moderate;
    logic signed [TempW-1:0] high_warn;
    logic [TempW-1:0]        spread_severe;
    logic [TempW-1:0]        spread_moderate;
  } cfg_t;

  // per-sample view after the scan stage
  typedef struct packed {
    logic [ClsW-1:0]         sensor_class;
    logic                    scan_done;
    logic signed [TempW-1:0] hi_temp;
    logic [IdxOW-1:0]        max_index;
    logic signed [TempW-1:0] lo_temp;
    logic [IdxOW-1:0]        min_index;
    logic [MaskW-1:0]        class_mask;
  } scan_info_t;

  typedef struct packed {
    logic [ClsW-1:0]         sensor_class;
    logic                    scan_done;
    logic signed [TempW-1:0] hi_temp;
    logic [IdxOW-1:0]        max_index;
    logic signed [TempW-1:0] lo_temp;
    logic [IdxOW-1:0]        min_index;
    logic signed [TempW-1:0] average;
    logic [ScW-1:0]          spread_class;
    logic [MaskW-1:0]        class_mask;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tsmma_cfg.sv
// apb threshold registers of the temperature scan supervisor
// depends on tsmma_pkg
`default_nettype none

module tsmma_cfg import tsmma_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e sel;
  logic     wr_en;
  logic [15:0] rd_val;

  assign sel    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_severe      <= LowSevereRst;
      cfg_q.low_moderate    <= LowModerateRst;
      cfg_q.low_warn        <= LowWarnRst;
      cfg_q.high_severe     <= HighSevereRst;
      cfg_q.high_moderate   <= HighModerateRst;
      cfg_q.high_warn       <= HighWarnRst;
      cfg_q.spread_severe   <= SpreadSevereRst;
      cfg_q.spread_moderate <= SpreadModerateRst;
    end else if (wr_en) begin
      case (sel)
        REG_LOW_SEVERE:      cfg_q.low_severe      <= pwdata[15:0];
        REG_LOW_MODERATE:    cfg_q.low_moderate    <= pwdata[15:0];
        REG_LOW_WARN:        cfg_q.low_warn        <= pwdata[15:0];
        REG_HIGH_SEVERE:     cfg_q.high_severe     <= pwdata[15:0];
        REG_HIGH_MODERATE:   cfg_q.high_moderate   <= pwdata[15:0];
        REG_HIGH_WARN:       cfg_q.high_warn       <= pwdata[15:0];
        REG_SPREAD_SEVERE:   cfg_q.spread_severe   <= pwdata[15:0];
        REG_SPREAD_MODERATE: cfg_q.spread_moderate <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LOW_SEVERE:      rd_val = cfg_q.low_severe;
      REG_LOW_MODERATE:    rd_val = cfg_q.low_moderate;
      REG_LOW_WARN:        rd_val = cfg_q.low_warn;
      REG_HIGH_SEVERE:     rd_val = cfg_q.high_severe;
      REG_HIGH_MODERATE:   rd_val = cfg_q.high_moderate;
      REG_HIGH_WARN:       rd_val = cfg_q.high_warn;
      REG_SPREAD_SEVERE:   rd_val = cfg_q.spread_severe;
      REG_SPREAD_MODERATE: rd_val = cfg_q.spread_moderate;
      default:             rd_val = '0;
    endcase
  end

  assign prdata = {16'b0, rd_val};

endmodule

`default_nettype wire

// File: rtl/tsmma_scan.sv
// input register, sample classing and running max/min/sum/mask of a scan
// depends on tsmma_pkg
`default_nettype none

module tsmma_scan import tsmma_pkg::*; #(
  parameter int unsigned SensorCount = SensorCountDef,
  localparam int unsigned IdxW = (SensorCount > 1) ? $clog2(SensorCount) : 1,
  localparam int unsigned SumW = TempW + $clog2(SensorCount)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [TempW-1:0]       sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output scan_info_t                  out_info_o,
  output logic signed [SumW-1:0]      out_sum_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SensorCount - 1);

  function automatic logic [ClsW-1:0] classify(logic signed [TempW-1:0] t, cfg_t c);
    sensor_class_e k;
    k = CLS_NORMAL;
    if (t < $signed(c.low_severe))         k = CLS_LOW_SEV;
    else if (t < $signed(c.low_moderate))  k = CLS_LOW_MOD;
    else if (t < $signed(c.low_warn))      k = CLS_LOW;
    if (t > $signed(c.high_severe))        k = CLS_HIGH_SEV;
    else if (t > $signed(c.high_moderate)) k = CLS_HIGH_MOD;
    else if (t > $signed(c.high_warn))     k = CLS_HIGH;
    return k;
  endfunction

  // input stage
  logic                    in_vld_q;
  logic signed [TempW-1:0] smp_q;

  // running scan state
  logic [IdxW-1:0]         idx_q;
  logic signed [TempW-1:0] max_q, max_d;
  logic signed [TempW-1:0] min_q, min_d;
  logic [IdxW-1:0]         maxi_q, maxi_d;
  logic [IdxW-1:0]         mini_q, mini_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [MaskW-1:0]        mask_q, mask_d;

  // output stage
  logic                    out_vld_q;
  scan_info_t              info_q, info_d;
  logic signed [SumW-1:0]  osum_q;

  logic            stage_rdy;
  logic            adv;
  logic            first;
  logic            last;
  logic [ClsW-1:0] cls;
  logic [IdxW+3:0] maxi_ext, mini_ext;

  assign stage_rdy  = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || stage_rdy;
  assign adv        = in_vld_q && stage_rdy;

  assign first = (idx_q == '0);
  assign last  = (idx_q == LastIdx);
  assign cls   = classify(smp_q, cfg_i);

  always_comb begin
    if (first) begin
      max_d  = smp_q;
      min_d  = smp_q;
      maxi_d = '0;
      mini_d = '0;
      sum_d  = SumW'(smp_q);
      mask_d = MaskW'(1) << cls;
    end else begin
      sum_d  = sum_q + SumW'(smp_q);
      mask_d = mask_q | (MaskW'(1) << cls);
      max_d  = max_q;
      maxi_d = maxi_q;
      min_d  = min_q;
      mini_d = mini_q;
      if (smp_q > max_q) begin
        max_d  = smp_q;
        maxi_d = idx_q;
      end
      if (smp_q < min_q) begin
        min_d  = smp_q;
        mini_d = idx_q;
      end
    end
  end

  // only the low nibble of the index is reported
  assign maxi_ext = {4'b0, maxi_d};
  assign mini_ext = {4'b0, mini_d};

  // summary fields read as zero except on the last sample
  always_comb begin
    info_d              = '0;
    info_d.sensor_class = cls;
    info_d.scan_done    = last;
    if (last) begin
      info_d.hi_temp    = max_d;
      info_d.max_index  = maxi_ext[3:0];
      info_d.lo_temp    = min_d;
      info_d.min_index  = mini_ext[3:0];
      info_d.class_mask = mask_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
      max_q     <= '0;
      min_q     <= '0;
      maxi_q    <= '0;
      mini_q    <= '0;
      sum_q     <= '0;
      mask_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (stage_rdy) begin
        out_vld_q <= in_vld_q;
      end
      if (adv) begin
        idx_q  <= last ? '0 : idx_q + 1'b1;
        max_q  <= max_d;
        min_q  <= min_d;
        maxi_q <= maxi_d;
        mini_q <= mini_d;
        sum_q  <= sum_d;
        mask_q <= mask_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      smp_q <= sample_i;
    end
    if (adv) begin
      info_q <= info_d;
      osum_q <= last ? sum_d : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_info_o  = info_q;
  assign out_sum_o   = osum_q;

endmodule

`default_nettype wire

// File: rtl/tsmma_summ.sv
// end-of-scan summary: spread class, and average by reciprocal multiply
// depends on tsmma_pkg
`default_nettype none

module tsmma_summ import tsmma_pkg::*; #(
  parameter int unsigned SensorCount = SensorCountDef,
  localparam int unsigned SumW = TempW + $clog2(SensorCount)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire scan_info_t             in_info_i,
  input  wire logic signed [SumW-1:0] in_sum_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output result_t                     out_res_o
);

  // |sum| < 2**SumW, so a reciprocal rounded up over SumW + log2 bits is exact
  localparam int unsigned Lw   = $clog2(SensorCount);
  localparam int unsigned Sh   = SumW + Lw;
  localparam int unsigned MulW = Sh + 1;
  localparam int unsigned PrdW = SumW + MulW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << Sh) + 64'(SensorCount) - 64'd1) / 64'(SensorCount);
  localparam logic [MulW-1:0] Recip = RecipFull[MulW-1:0];

  logic rdy2, rdy3, rdy4;
  logic v2_q, v3_q, v4_q;

  // stage 2: spread class and sign/magnitude split
  scan_info_t       info2_q, info2_d;
  logic [ScW-1:0]   sc2_q, sc2_d;
  logic [SumW-1:0]  abs2_q, abs2_d;
  logic             neg2_q;
  logic [TempW-1:0] spread;

  // stage 3: quotient magnitude
  scan_info_t       info3_q;
  logic [ScW-1:0]   sc3_q;
  logic             neg3_q;
  logic [TempW:0]   quot3_q;
  logic [PrdW-1:0]  prod;

  // stage 4: output register
  result_t          res_q, res_d;
  logic [TempW:0]   avg_full;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  assign spread = in_info_i.hi_temp - in_info_i.lo_temp;

  always_comb begin
    info2_d = in_info_i;
    sc2_d   = SPREAD_NORMAL;
    if (in_info_i.scan_done) begin
      if (spread > cfg_i.spread_severe) begin
        sc2_d = SPREAD_SEVERE;
        info2_d.class_mask[MaskSevereBit] = 1'b1;
      end else if (spread > cfg_i.spread_moderate) begin
        sc2_d = SPREAD_MODERATE;
        info2_d.class_mask[MaskModerateBit] = 1'b1;
      end else begin
        info2_d.class_mask[MaskNormalBit] = 1'b1;
      end
    end
    abs2_d = in_sum_i[SumW-1] ? SumW'(-in_sum_i) : SumW'(in_sum_i);
  end

  assign prod = PrdW'(abs2_q) * PrdW'(Recip);

  // truncation toward zero: divide the magnitude, then restore the sign
  assign avg_full = neg3_q ? (TempW+1)'(-quot3_q) : quot3_q;

  always_comb begin
    res_d.sensor_class = info3_q.sensor_class;
    res_d.scan_done    = info3_q.scan_done;
    res_d.hi_temp      = info3_q.hi_temp;
    res_d.max_index    = info3_q.max_index;
    res_d.lo_temp      = info3_q.lo_temp;
    res_d.min_index    = info3_q.min_index;
    res_d.average      = avg_full[TempW-1:0];
    res_d.spread_class = sc3_q;
    res_d.class_mask   = info3_q.class_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= in_valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      info2_q <= info2_d;
      sc2_q   <= sc2_d;
      abs2_q  <= abs2_d;
      neg2_q  <= in_sum_i[SumW-1];
    end
    if (rdy3 && v2_q) begin
      info3_q <= info2_q;
      sc3_q   <= sc2_q;
      neg3_q  <= neg2_q;
      quot3_q <= prod[Sh+TempW:Sh];
    end
    if (rdy4 && v3_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

// File: rtl/temp_scan_min_max_alarm.sv
// temperature scan supervisor, top level
// depends on tsmma_pkg, tsmma_cfg, tsmma_scan, tsmma_summ and the macro header
`default_nettype none
`include "temp_scan_min_max_alarm_macros.svh"

// one signed 16-bit sample is taken per transfer, in sensor order, and a scan is
// SensorCount samples long. every sample gives one result transfer carrying its
// class against the six low/high thresholds; the last sample of a scan is
// flagged with tlast and also carries the scan max and min with the index of
// the first sample that reached each (low four bits), the average truncated
// toward zero, the spread class and the mask of classes seen. on other samples
// the summary fields are zero. the block takes one sample every clock cycle
// when the output side keeps up; a sample's result passes through the input
// register, scan stage, spread stage, reciprocal multiply stage and output
// register. the running max/min/sum compare and add in the scan stage is the
// loop that sets this rate, and the average uses a constant reciprocal multiply
// instead of a divider. every stage has its own valid bit, so a stalled output
// still lets samples move into empty stages. thresholds sit behind an apb port
// at byte address 4*i and should be written between scans.
// there is no clearing pass after reset.

module temp_scan_min_max_alarm import tsmma_pkg::*; #(
  parameter int unsigned SensorCount = SensorCountDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] sensor_class, [18:3] scan max, [22:19] max_index, [38:23] scan min,
  // [42:39] min_index, [58:43] average, [60:59] spread_class,
  // [69:61] class_mask, [71:70] zero
  output logic [71:0]      m_axis_tdata,
  output logic             m_axis_tlast,   // scan_done
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned SumW = TempW + $clog2(SensorCount);

  cfg_t                   cfg;
  logic                   scan_vld;
  logic                   scan_rdy;
  scan_info_t             scan_info;
  logic signed [SumW-1:0] scan_sum;
  result_t                m_res;

  // threshold registers
  tsmma_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // classing and running statistics
  tsmma_scan #(
    .SensorCount (SensorCount)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata),
    .out_valid_o (scan_vld),
    .out_ready_i (scan_rdy),
    .out_info_o  (scan_info),
    .out_sum_o   (scan_sum)
  );

  // spread class, average and output register
  tsmma_summ #(
    .SensorCount (SensorCount)
  ) u_summ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (scan_vld),
    .in_ready_o  (scan_rdy),
    .in_info_i   (scan_info),
    .in_sum_i    (scan_sum),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (m_res)
  );

  assign m_axis_tlast = m_res.scan_done;
  assign m_axis_tdata = {2'b0, m_res.class_mask, m_res.spread_class, m_res.average,
                         m_res.min_index, m_res.lo_temp, m_res.max_index,
                         m_res.hi_temp, m_res.sensor_class};

  // mid-scan results carry no summary
  `TSMMA_ASSERT(a_mid_scan_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, (m_res.hi_temp == '0) && (m_res.lo_temp == '0) && (m_res.average == '0) && (m_res.class_mask == '0) && (m_res.spread_class == SPREAD_NORMAL))
  // the last sample's own class is always part of the scan mask
  `TSMMA_ASSERT(a_last_class_in_mask, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_res.class_mask[m_res.sensor_class] && (m_res.spread_class != SPREAD_UNUSED))
  // max never falls below min, and the average lies between them
  `TSMMA_ASSERT(a_max_ge_min, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, ($signed(m_res.hi_temp) >= $signed(m_res.average)) && ($signed(m_res.average) >= $signed(m_res.lo_temp)))
  // a write to the high warn register lands in that threshold
  `TSMMA_ASSERT_NEXT(a_cfg_write, clk_i, rst_ni, psel && penable && pwrite && (paddr[4:2] == REG_HIGH_WARN), cfg.high_warn == $past(pwdata[15:0]))

endmodule

`default_nettype wire
